### hdl/bbpa_pkg.sv
// Types and constants shared by the buffer pool allocator modules.
`timescale 1ns / 1ps

package bbpa_pkg;

    // Slot and rank fields are sized for the largest supported table (64 blocks).
    localparam int IDX_W = 6;

    localparam logic CFG_BUDGET = 1'b0;
    localparam logic [31:0] BUDGET_RESET = 32'd268435456;

    typedef enum logic [2:0] {
        STAT_GRANTED   = 3'd0,
        STAT_NULL      = 3'd1,
        STAT_TOO_LARGE = 3'd2,
        STAT_MUST_WAIT = 3'd3,
        STAT_FULL      = 3'd4,
        STAT_RELEASED  = 3'd5,
        STAT_UNKNOWN   = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_RELEASE,
        CMD_REUSE,
        CMD_APPEND
    } cmd_op_t;

    typedef struct packed {
        logic        req_type;
        logic [31:0] request_bytes;
        logic [3:0]  release_slot;
        logic [31:0] release_bytes;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [3:0]  granted_slot;
        logic [31:0] granted_capacity;
        logic        reused;
        logic        evicted;
        logic [3:0]  evicted_slot;
        logic [31:0] outstanding_after;
    } rsp_t;

    // Search record handed from cell to cell.
    typedef struct packed {
        logic             go;
        logic             fit_found;
        logic [IDX_W-1:0] fit_rank;
        logic [IDX_W-1:0] fit_slot;
        logic [31:0]      fit_cap;
        logic             idle_found;
        logic [IDX_W-1:0] idle_rank;
        logic [IDX_W-1:0] idle_slot;
        logic             free_found;
        logic [IDX_W-1:0] free_slot;
    } scan_t;

    // Update broadcast to all cells.
    typedef struct packed {
        cmd_op_t          op;
        logic [IDX_W-1:0] slot;
        logic             evict;
        logic [IDX_W-1:0] evict_slot;
        logic [IDX_W-1:0] evict_rank;
        logic [IDX_W-1:0] new_rank;
        logic [31:0]      size;
    } cmd_t;

endpackage

### hdl/bbpa_cell.sv
// One table slot: holds its block state and refines the search record in transit.
`timescale 1ns / 1ps

module bbpa_cell #(
    parameter int SLOT = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  bbpa_pkg::scan_t scan_in,
    input  bbpa_pkg::cmd_t  cmd,
    output bbpa_pkg::scan_t scan_out,
    output logic            valid
);

    localparam logic [bbpa_pkg::IDX_W-1:0] MY_SLOT = bbpa_pkg::IDX_W'(SLOT);

    logic                        valid_reg, valid_next;
    logic                        busy_reg, busy_next;
    logic [bbpa_pkg::IDX_W-1:0]  rank_reg, rank_next;
    logic [31:0]                 cap_reg, cap_next;
    bbpa_pkg::scan_t             scan_reg, scan_next;
    logic                        cand;

    assign cand = valid_reg && !busy_reg;

    always_comb
    begin
        scan_next = scan_in;
        if (cand && (cap_reg >= cmd.size)
            && (!scan_in.fit_found || (rank_reg < scan_in.fit_rank)))
        begin
            scan_next.fit_found = 1'b1;
            scan_next.fit_rank  = rank_reg;
            scan_next.fit_slot  = MY_SLOT;
            scan_next.fit_cap   = cap_reg;
        end
        if (cand && (!scan_in.idle_found || (rank_reg < scan_in.idle_rank)))
        begin
            scan_next.idle_found = 1'b1;
            scan_next.idle_rank  = rank_reg;
            scan_next.idle_slot  = MY_SLOT;
        end
        if (!valid_reg && !scan_in.free_found)
        begin
            scan_next.free_found = 1'b1;
            scan_next.free_slot  = MY_SLOT;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        busy_next  = busy_reg;
        rank_next  = rank_reg;
        cap_next   = cap_reg;
        case (cmd.op)
            bbpa_pkg::CMD_RELEASE:
            begin
                if (cmd.slot == MY_SLOT)
                begin
                    busy_next = 1'b0;
                end
            end
            bbpa_pkg::CMD_REUSE:
            begin
                if (cmd.slot == MY_SLOT)
                begin
                    busy_next = 1'b1;
                end
            end
            bbpa_pkg::CMD_APPEND:
            begin
                if (cmd.evict)
                begin
                    if (cmd.evict_slot == MY_SLOT)
                    begin
                        valid_next = 1'b0;
                        busy_next  = 1'b0;
                    end
                    else if (valid_reg && (rank_reg > cmd.evict_rank))
                    begin
                        rank_next = rank_reg - bbpa_pkg::IDX_W'(1);
                    end
                end
                if (cmd.slot == MY_SLOT)
                begin
                    valid_next = 1'b1;
                    busy_next  = 1'b1;
                    rank_next  = cmd.new_rank;
                    cap_next   = cmd.size;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            busy_reg  <= 1'b0;
            rank_reg  <= '0;
            scan_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            busy_reg  <= busy_next;
            rank_reg  <= rank_next;
            scan_reg  <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cap_reg <= cap_next;
    end

    assign scan_out = scan_reg;
    assign valid    = valid_reg;

endmodule

### hdl/budgeted_buffer_pool_allocator_unit.sv
// Top level of the budgeted first-fit buffer pool allocator.
`timescale 1ns / 1ps
//
// Requests arrive on req (req_valid/req_ready) and each gives exactly one
// response on rsp (rsp_valid/rsp_ready). An acquire reuses the first idle
// block in order that is large enough, else evicts the first idle block, if
// any, and appends a new one; a release marks a block idle. Outstanding
// bytes are held against the budget, written through the APB port at
// address 0. One request is handled at a time. Releases and acquires
// rejected by the size and budget checks go from the check state straight
// to the done state; acquires that search the table pass through the scan
// state while the search record steps through the row of slot cells one
// cell per cycle. The next request is taken as soon as the response is
// parked in the output register, so a stalled receiver costs nothing
// until a second response is ready. Reset empties the table, zeroes the
// outstanding total and restores the default budget; no clearing pass is
// needed.

module budgeted_buffer_pool_allocator_unit #(
    parameter int MAX_BLOCKS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  bbpa_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output bbpa_pkg::rsp_t  rsp,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    localparam int SW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int TW = $clog2(MAX_BLOCKS + 1);
    localparam int IW = bbpa_pkg::IDX_W;

    bbpa_pkg::state_t  state_reg, state_next;
    bbpa_pkg::req_t    item_reg;
    bbpa_pkg::rsp_t    res_reg, res_next;
    bbpa_pkg::rsp_t    rsp_reg;
    logic              rsp_valid_reg;
    logic [31:0]       budget_reg;
    logic [31:0]       outstanding_reg, outstanding_next;
    logic [TW-1:0]     total_reg, total_next;

    bbpa_pkg::cmd_t    cmd;
    bbpa_pkg::scan_t   head;
    bbpa_pkg::scan_t   chain [MAX_BLOCKS];
    bbpa_pkg::scan_t   tail;
    logic [MAX_BLOCKS-1:0] valid_vec;

    logic              launch;
    logic              rsp_load;
    logic              rel_ok;
    logic [SW-1:0]     rel_idx;
    logic [32:0]       sum_req;
    logic [IW-1:0]     place_slot;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == bbpa_pkg::CFG_BUDGET) ? budget_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg <= bbpa_pkg::BUDGET_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == bbpa_pkg::CFG_BUDGET))
        begin
            budget_reg <= pwdata;
        end
    end

    // ---------------- slot cells ----------------
    always_comb
    begin
        head            = '0;
        head.go         = launch;
    end

    for (genvar i = 0; i < MAX_BLOCKS; i++)
    begin : g_cell
        bbpa_cell #(
            .SLOT (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .scan_in  ((i == 0) ? head : chain[(i == 0) ? 0 : i - 1]),
            .cmd      (cmd),
            .scan_out (chain[i]),
            .valid    (valid_vec[i])
        );
    end

    assign tail = chain[MAX_BLOCKS-1];

    // ---------------- control ----------------
    assign rel_idx  = SW'(item_reg.release_slot);
    assign rel_ok   = ({28'd0, item_reg.release_slot} < 32'(MAX_BLOCKS)) && valid_vec[rel_idx];
    assign sum_req  = {1'b0, outstanding_reg} + {1'b0, item_reg.request_bytes};
    assign place_slot = (tail.idle_found && !(tail.free_found
                         && (tail.free_slot < tail.idle_slot))) ? tail.idle_slot
                                                                : tail.free_slot;
    assign req_ready = (state_reg == bbpa_pkg::ST_IDLE);
    assign rsp_load  = (state_reg == bbpa_pkg::ST_DONE) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        state_next       = state_reg;
        res_next         = res_reg;
        outstanding_next = outstanding_reg;
        total_next       = total_reg;
        launch           = 1'b0;
        cmd.op           = bbpa_pkg::CMD_NONE;
        cmd.slot         = '0;
        cmd.evict        = 1'b0;
        cmd.evict_slot   = '0;
        cmd.evict_rank   = '0;
        cmd.new_rank     = '0;
        cmd.size         = item_reg.request_bytes;
        unique case (state_reg)
            bbpa_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = bbpa_pkg::ST_CHECK;
                end
            end
            bbpa_pkg::ST_CHECK:
            begin
                res_next                   = '0;
                res_next.outstanding_after = outstanding_reg;
                state_next                 = bbpa_pkg::ST_DONE;
                if (item_reg.req_type)
                begin
                    if (rel_ok)
                    begin
                        cmd.op   = bbpa_pkg::CMD_RELEASE;
                        cmd.slot = IW'(item_reg.release_slot);
                        outstanding_next = (item_reg.release_bytes < outstanding_reg)
                                           ? (outstanding_reg - item_reg.release_bytes)
                                           : 32'd0;
                        res_next.status            = bbpa_pkg::STAT_RELEASED;
                        res_next.outstanding_after = outstanding_next;
                    end
                    else
                    begin
                        res_next.status = bbpa_pkg::STAT_UNKNOWN;
                    end
                end
                else if (item_reg.request_bytes == 32'd0)
                begin
                    res_next.status = bbpa_pkg::STAT_NULL;
                end
                else if (item_reg.request_bytes > budget_reg)
                begin
                    res_next.status = bbpa_pkg::STAT_TOO_LARGE;
                end
                else if (sum_req > {1'b0, budget_reg})
                begin
                    res_next.status = bbpa_pkg::STAT_MUST_WAIT;
                end
                else
                begin
                    launch     = 1'b1;
                    state_next = bbpa_pkg::ST_SCAN;
                end
            end
            bbpa_pkg::ST_SCAN:
            begin
                if (tail.go)
                begin
                    state_next = bbpa_pkg::ST_DONE;
                    if (tail.fit_found)
                    begin
                        cmd.op                     = bbpa_pkg::CMD_REUSE;
                        cmd.slot                   = tail.fit_slot;
                        outstanding_next           = sum_req[31:0];
                        res_next.status            = bbpa_pkg::STAT_GRANTED;
                        res_next.granted_slot      = 4'(tail.fit_slot);
                        res_next.granted_capacity  = tail.fit_cap;
                        res_next.reused            = 1'b1;
                        res_next.outstanding_after = outstanding_next;
                    end
                    else if (!tail.idle_found && !tail.free_found)
                    begin
                        res_next.status = bbpa_pkg::STAT_FULL;
                    end
                    else
                    begin
                        cmd.op         = bbpa_pkg::CMD_APPEND;
                        cmd.slot       = place_slot;
                        cmd.evict      = tail.idle_found;
                        cmd.evict_slot = tail.idle_slot;
                        cmd.evict_rank = tail.idle_rank;
                        cmd.new_rank   = IW'(total_reg - TW'(tail.idle_found));
                        total_next     = total_reg - TW'(tail.idle_found) + TW'(1);
                        outstanding_next           = sum_req[31:0];
                        res_next.status            = bbpa_pkg::STAT_GRANTED;
                        res_next.granted_slot      = 4'(place_slot);
                        res_next.granted_capacity  = item_reg.request_bytes;
                        res_next.evicted           = tail.idle_found;
                        res_next.evicted_slot      = tail.idle_found ? 4'(tail.idle_slot) : 4'd0;
                        res_next.outstanding_after = outstanding_next;
                    end
                end
            end
            bbpa_pkg::ST_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = bbpa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bbpa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= bbpa_pkg::ST_IDLE;
            outstanding_reg <= 32'd0;
            total_reg       <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            outstanding_reg <= outstanding_next;
            total_reg       <= total_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            item_reg <= req;
        end
        res_reg <= res_next;
        if (rsp_load)
        begin
            rsp_reg <= res_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### tb/sv/budgeted_buffer_pool_allocator_unit_checker.sv
// Checker: predicts allocator responses and compares them with the block.
`timescale 1ns / 1ps

module budgeted_buffer_pool_allocator_unit_checker #(
    parameter int MAX_BLOCKS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            req_ready,
    input  bbpa_pkg::req_t  req,
    input  logic            rsp_valid,
    input  logic            rsp_ready,
    input  bbpa_pkg::rsp_t  rsp,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    input  logic [31:0]     prdata,
    input  logic            pready,
    output int              errors,
    output int              pending
);

    logic           slot_valid [MAX_BLOCKS];
    logic           slot_busy  [MAX_BLOCKS];
    logic [31:0]    slot_cap   [MAX_BLOCKS];
    int             slot_rank  [MAX_BLOCKS];
    int             block_count;
    logic [31:0]    outstanding;
    logic [31:0]    budget;
    bbpa_pkg::rsp_t grant_q [$];

    localparam logic [2:0] BUDGET_ADDR = 3'(4 * bbpa_pkg::CFG_BUDGET);

    initial errors = 0;
    initial pending = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t mismatch %s: got 0x%08h expected 0x%08h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic pool_apply(input bbpa_pkg::req_t it, output bbpa_pkg::rsp_t r);
        int fit;
        int idle;
        int free_s;
        int r_old;
        r = '0;
        r.status = bbpa_pkg::STAT_GRANTED;
        if (it.req_type) begin
            if (int'(it.release_slot) >= MAX_BLOCKS || !slot_valid[it.release_slot]) begin
                r.status = bbpa_pkg::STAT_UNKNOWN;
            end
            else begin
                slot_busy[it.release_slot] = 1'b0;
                outstanding -= (it.release_bytes < outstanding) ? it.release_bytes : outstanding;
                r.status = bbpa_pkg::STAT_RELEASED;
            end
        end
        else if (it.request_bytes == 32'd0) begin
            r.status = bbpa_pkg::STAT_NULL;
        end
        else if (it.request_bytes > budget) begin
            r.status = bbpa_pkg::STAT_TOO_LARGE;
        end
        else if ({1'b0, outstanding} + {1'b0, it.request_bytes} > {1'b0, budget}) begin
            r.status = bbpa_pkg::STAT_MUST_WAIT;
        end
        else begin
            fit = -1;
            idle = -1;
            for (int s = 0; s < MAX_BLOCKS; s++) begin
                if (slot_valid[s] && !slot_busy[s]) begin
                    if (slot_cap[s] >= it.request_bytes
                        && (fit < 0 || slot_rank[s] < slot_rank[fit]))
                        fit = s;
                    if (idle < 0 || slot_rank[s] < slot_rank[idle])
                        idle = s;
                end
            end
            if (fit >= 0) begin
                slot_busy[fit] = 1'b1;
                r.granted_slot = 4'(fit);
                r.granted_capacity = slot_cap[fit];
                r.reused = 1'b1;
                outstanding += it.request_bytes;
            end
            else if (idle < 0 && block_count >= MAX_BLOCKS) begin
                r.status = bbpa_pkg::STAT_FULL;
            end
            else begin
                if (idle >= 0) begin
                    r_old = slot_rank[idle];
                    slot_valid[idle] = 1'b0;
                    slot_busy[idle] = 1'b0;
                    for (int s = 0; s < MAX_BLOCKS; s++)
                        if (slot_valid[s] && slot_rank[s] > r_old)
                            slot_rank[s]--;
                    if (block_count > 0)
                        block_count--;
                    r.evicted = 1'b1;
                    r.evicted_slot = 4'(idle);
                end
                free_s = -1;
                for (int s = MAX_BLOCKS - 1; s >= 0; s--)
                    if (!slot_valid[s])
                        free_s = s;
                slot_valid[free_s] = 1'b1;
                slot_busy[free_s] = 1'b1;
                slot_cap[free_s] = it.request_bytes;
                slot_rank[free_s] = block_count;
                block_count++;
                r.granted_slot = 4'(free_s);
                r.granted_capacity = it.request_bytes;
                outstanding += it.request_bytes;
            end
        end
        r.outstanding_after = outstanding;
    endtask

    always @(posedge clk or negedge rst_n) begin
        bbpa_pkg::rsp_t want;
        bbpa_pkg::rsp_t next;
        if (!rst_n) begin
            for (int s = 0; s < MAX_BLOCKS; s++) begin
                slot_valid[s] = 1'b0;
                slot_busy[s] = 1'b0;
                slot_cap[s] = '0;
                slot_rank[s] = 0;
            end
            block_count = 0;
            outstanding = '0;
            budget = bbpa_pkg::BUDGET_RESET;
            grant_q.delete();
        end
        else begin
            if (rsp_valid && rsp_ready) begin
                if (grant_q.size() == 0) begin
                    report("unexpected response status", 32'(rsp.status), 32'd0);
                end
                else begin
                    want = grant_q.pop_front();
                    if (rsp.status !== want.status)
                        report("status", 32'(rsp.status), 32'(want.status));
                    if (rsp.granted_slot !== want.granted_slot)
                        report("granted_slot", 32'(rsp.granted_slot), 32'(want.granted_slot));
                    if (rsp.granted_capacity !== want.granted_capacity)
                        report("granted_capacity", rsp.granted_capacity, want.granted_capacity);
                    if (rsp.reused !== want.reused)
                        report("reused", 32'(rsp.reused), 32'(want.reused));
                    if (rsp.evicted !== want.evicted)
                        report("evicted", 32'(rsp.evicted), 32'(want.evicted));
                    if (rsp.evicted_slot !== want.evicted_slot)
                        report("evicted_slot", 32'(rsp.evicted_slot), 32'(want.evicted_slot));
                    if (rsp.outstanding_after !== want.outstanding_after)
                        report("outstanding_after", rsp.outstanding_after,
                               want.outstanding_after);
                end
            end
            if (req_valid && req_ready) begin
                pool_apply(req, next);
                grant_q = {grant_q, next};
            end
            if (psel && penable && pready && paddr == BUDGET_ADDR) begin
                if (pwrite)
                    budget = pwdata;
                else if (prdata !== budget)
                    report("budget readback", prdata, budget);
            end
        end
        pending = grant_q.size();
    end

endmodule

### tb/sv/budgeted_buffer_pool_allocator_unit_test.sv
// Testbench top: drives requests, budget writes and response backpressure.
`timescale 1ns / 1ps

module budgeted_buffer_pool_allocator_unit_test;

    localparam int MAX_BLOCKS = 16;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_ready;
    bbpa_pkg::req_t req;
    logic           rsp_valid;
    logic           rsp_ready;
    bbpa_pkg::rsp_t rsp;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [2:0]     paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;
    int             errors;
    int             pending;
    bit             hold_kick;
    int             burst_left;

    budgeted_buffer_pool_allocator_unit #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    budgeted_buffer_pool_allocator_unit_checker #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .errors(errors),
        .pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #(10_000_000);
        $display("FAIL");
        $finish;
    end

    // receiver backpressure
    initial begin
        int hold_left;
        int pat_left;
        int mode;
        hold_left = 0;
        pat_left = 0;
        mode = 0;
        rsp_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_kick) begin
                hold_kick = 1'b0;
                hold_left = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else begin
                if (pat_left == 0) begin
                    pat_left = $urandom_range(5, 60);
                    mode = $urandom_range(0, 2);
                end
                pat_left--;
                case (mode)
                    0: rsp_ready <= 1'b1;
                    1: rsp_ready <= 1'($urandom_range(0, 1));
                    default: rsp_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    function automatic bbpa_pkg::req_t acquire(input logic [31:0] bytes);
        bbpa_pkg::req_t it;
        it = {1'b0, bytes, 4'($urandom), 32'($urandom)};
        return it;
    endfunction

    function automatic bbpa_pkg::req_t release_blk(input logic [3:0] slot,
                                                   input logic [31:0] bytes);
        bbpa_pkg::req_t it;
        it = {1'b1, 32'($urandom), slot, bytes};
        return it;
    endfunction

    function automatic bbpa_pkg::req_t make_item(input int acq_pct, input int unsigned cap);
        bbpa_pkg::req_t it;
        int             k;
        it.req_type = ($urandom_range(0, 99) >= acq_pct);
        it.request_bytes = $urandom;
        it.release_slot = 4'($urandom);
        it.release_bytes = $urandom;
        k = $urandom_range(0, 99);
        if (!it.req_type) begin
            if (k < 3)
                it.request_bytes = '0;
            else if (k >= 8)
                it.request_bytes = $urandom_range(1, cap);
        end
        else begin
            if (k < 5)
                it.release_bytes = 32'hFFFF_FFFF;
            else if (k >= 10)
                it.release_bytes = $urandom_range(0, cap);
        end
        return it;
    endfunction

    task automatic send_item(input bbpa_pkg::req_t it);
        @(negedge clk);
        req_valid <= 1'b1;
        req <= it;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic idle_for(input int n);
        if (n > 0) begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic drain;
        @(negedge clk);
        req_valid <= 1'b0;
        wait (pending == 0);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= 3'(4 * bbpa_pkg::CFG_BUDGET);
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic run_phase(input logic [31:0] budget, input int count, input int acq_pct,
                             input int unsigned cap, input int hold_at, input int pause_at);
        drain();
        apb_access(1'b1, budget);
        apb_access(1'b0, '0);
        for (int i = 0; i < count; i++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
            end
            send_item(make_item(acq_pct, cap));
            burst_left--;
            if (i == hold_at)
                hold_kick = 1'b1;
            if (i == pause_at)
                drain();
        end
    endtask

    initial begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_kick = 1'b0;
        burst_left = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_item(acquire(32'd0));
        send_item(acquire(32'hFFFF_FFFF));
        send_item(release_blk(4'd0, 32'd5));
        send_item(release_blk(4'd15, 32'd5));
        for (int i = 0; i < MAX_BLOCKS; i++)
            send_item(acquire(32'h0010_0000 * (i + 1) + i));
        send_item(acquire(32'd7));
        send_item(release_blk(4'd3, 32'hFFFF_FFFF));
        send_item(release_blk(4'd3, 32'd1));
        send_item(acquire(bbpa_pkg::BUDGET_RESET));
        send_item(acquire(32'd1));

        run_phase(bbpa_pkg::BUDGET_RESET, 350, 60, 4096, 120, -1);
        run_phase(32'd0, 100, 50, 1000, -1, -1);
        run_phase(32'hFFFF_FFFF, 350, 75, 32'h1000_0000, 200, -1);
        run_phase(32'd5000, 350, 55, 1200, 60, 175);
        run_phase(32'd300, 350, 60, 64, -1, -1);
        run_phase($urandom, 350, 60, 32'h0100_0000, 250, -1);

        drain();
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
